/* design/i2c_master_register_access_defines.svh */
// Assertion macros for the I2C register access master checker.
// Used by i2cm_checker.sv; expects clk and rst in the calling scope.
`ifndef I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH
`define I2C_MASTER_REGISTER_ACCESS_DEFINES_SVH

// checked only outside reset
`define I2CM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/i2cm_pkg.sv */
// Shared types and constants for the I2C register access master.
// No dependencies.
package i2cm_pkg;

  typedef struct packed {
    logic       req_valid;
    logic       req_type;
    logic [7:0] reg_addr;
    logic [7:0] wr_data;
    logic       sda_in;
  } req_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rd_data;
    logic       nack_seen;
  } res_t;

  typedef enum logic [16:0] {
    ST_IDLE   = 17'b0_0000_0000_0000_0001,
    ST_STA_A  = 17'b0_0000_0000_0000_0010,
    ST_STA_B  = 17'b0_0000_0000_0000_0100,
    ST_BIT_LO = 17'b0_0000_0000_0000_1000,
    ST_BIT_HI = 17'b0_0000_0000_0001_0000,
    ST_ACK_LO = 17'b0_0000_0000_0010_0000,
    ST_ACK_HI = 17'b0_0000_0000_0100_0000,
    ST_RS_A   = 17'b0_0000_0000_1000_0000,
    ST_RS_B   = 17'b0_0000_0001_0000_0000,
    ST_RS_C   = 17'b0_0000_0010_0000_0000,
    ST_RD_LO  = 17'b0_0000_0100_0000_0000,
    ST_RD_HI  = 17'b0_0000_1000_0000_0000,
    ST_NAK_LO = 17'b0_0001_0000_0000_0000,
    ST_NAK_HI = 17'b0_0010_0000_0000_0000,
    ST_STO_A  = 17'b0_0100_0000_0000_0000,
    ST_STO_B  = 17'b0_1000_0000_0000_0000,
    ST_STO_C  = 17'b1_0000_0000_0000_0000
  } state_t;

  typedef logic [1:0] byte_idx_t;
  localparam byte_idx_t BYTE_DEV  = 2'd0;
  localparam byte_idx_t BYTE_REG  = 2'd1;
  localparam byte_idx_t BYTE_LAST = 2'd2;

  localparam logic       REQ_WRITE = 1'b0;
  localparam logic       REQ_READ  = 1'b1;

  localparam logic       CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic       CFG_PHASE_TICKS    = 1'b1;
  localparam int         CFG_DATA_W         = 8;

  localparam logic [6:0] DEV_ADDR_RESET    = 7'd104;
  localparam logic [7:0] PHASE_TICKS_RESET = 8'd10;
  localparam logic [3:0] BITS_PER_BYTE     = 4'd8;

endpackage

/* design/i2cm_req_if.sv */
// Request channel: valid/ready handshake carrying one tick item.
// Depends on i2cm_pkg.
interface i2cm_req_if;
  logic          valid;
  logic          ready;
  i2cm_pkg::req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/i2cm_res_if.sv */
// Result channel: valid/ready handshake carrying one bus drive item.
// Depends on i2cm_pkg.
interface i2cm_res_if;
  logic          valid;
  logic          ready;
  i2cm_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/i2c_master_register_access.sv */
// I2C register access master: one result beat per request beat.
// A result beat is registered as its request is taken: in the output register, or in the skid.
// Throughput: one beat per cycle while the skid is empty; a two-entry output stage
// (register plus skid) lets a request beat be taken while one result waits.
// Reset (rst, synchronous): sequencer idle, counters and flags cleared,
// output stage empty, device_address 104, phase_ticks 10.
module i2c_master_register_access (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [i2cm_pkg::CFG_DATA_W-1:0] cfg_data,
  i2cm_req_if.sink                        req_ch,
  i2cm_res_if.source                      res_ch
);

  logic [6:0]          device_address;
  logic [7:0]          phase_ticks;

  i2cm_pkg::state_t    state, state_next;
  logic [7:0]          phase_count, phase_count_next;
  logic [3:0]          bit_count, bit_count_next;
  logic [7:0]          shift_byte, shift_byte_next;
  logic                held_type, held_type_next;
  logic [7:0]          held_reg, held_reg_next;
  logic [7:0]          held_data, held_data_next;
  logic [7:0]          read_byte, read_byte_next;
  logic                nack_flag, nack_flag_next;
  i2cm_pkg::byte_idx_t byte_index, byte_index_next;

  logic                done;
  logic [7:0]          phase_inc;
  logic [3:0]          bit_inc;
  logic [7:0]          rd_shift;
  i2cm_pkg::res_t      res_new;

  logic                out_valid, skid_valid;
  i2cm_pkg::res_t      out_data, skid_data;
  logic                accept;

  assign req_ch.ready = !skid_valid;
  assign accept       = req_ch.valid && req_ch.ready;
  assign res_ch.valid = out_valid;
  assign res_ch.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2cm_pkg::DEV_ADDR_RESET;
      phase_ticks    <= i2cm_pkg::PHASE_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cm_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[6:0];
        i2cm_pkg::CFG_PHASE_TICKS:    phase_ticks    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign phase_inc = phase_count + 8'd1;
  assign bit_inc   = bit_count + 4'd1;
  assign rd_shift  = {shift_byte[6:0], req_ch.data.sda_in};

  always_comb begin
    state_next       = state;
    phase_count_next = phase_count;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    held_type_next   = held_type;
    held_reg_next    = held_reg;
    held_data_next   = held_data;
    read_byte_next   = read_byte;
    nack_flag_next   = nack_flag;
    byte_index_next  = byte_index;
    done             = 1'b0;

    if (state == i2cm_pkg::ST_IDLE) begin
      if (req_ch.data.req_valid) begin
        held_type_next   = req_ch.data.req_type;
        held_reg_next    = req_ch.data.reg_addr;
        held_data_next   = req_ch.data.wr_data;
        nack_flag_next   = 1'b0;
        phase_count_next = 8'd0;
        bit_count_next   = 4'd0;
        byte_index_next  = i2cm_pkg::BYTE_DEV;
        state_next       = i2cm_pkg::ST_STA_A;
      end
    end else if (phase_inc < phase_ticks) begin
      phase_count_next = phase_inc;
    end else begin
      phase_count_next = 8'd0;
      unique case (state)
        i2cm_pkg::ST_STA_A: state_next = i2cm_pkg::ST_STA_B;
        i2cm_pkg::ST_STA_B: begin
          shift_byte_next = {device_address, 1'b0};
          bit_count_next  = 4'd0;
          byte_index_next = i2cm_pkg::BYTE_DEV;
          state_next      = i2cm_pkg::ST_BIT_LO;
        end
        i2cm_pkg::ST_BIT_LO: state_next = i2cm_pkg::ST_BIT_HI;
        i2cm_pkg::ST_BIT_HI: begin
          shift_byte_next = {shift_byte[6:0], 1'b0};
          bit_count_next  = bit_inc;
          state_next      = (bit_inc >= i2cm_pkg::BITS_PER_BYTE) ?
                            i2cm_pkg::ST_ACK_LO : i2cm_pkg::ST_BIT_LO;
        end
        i2cm_pkg::ST_ACK_LO: state_next = i2cm_pkg::ST_ACK_HI;
        i2cm_pkg::ST_ACK_HI: begin
          if (req_ch.data.sda_in) nack_flag_next = 1'b1;
          priority if (byte_index == i2cm_pkg::BYTE_DEV) begin
            shift_byte_next = held_reg;
            bit_count_next  = 4'd0;
            byte_index_next = i2cm_pkg::BYTE_REG;
            state_next      = i2cm_pkg::ST_BIT_LO;
          end else if (byte_index == i2cm_pkg::BYTE_REG) begin
            if (held_type == i2cm_pkg::REQ_READ) begin
              state_next = i2cm_pkg::ST_RS_A;
            end else begin
              shift_byte_next = held_data;
              bit_count_next  = 4'd0;
              byte_index_next = i2cm_pkg::BYTE_LAST;
              state_next      = i2cm_pkg::ST_BIT_LO;
            end
          end else if (held_type == i2cm_pkg::REQ_READ) begin
            shift_byte_next = 8'd0;
            bit_count_next  = 4'd0;
            state_next      = i2cm_pkg::ST_RD_LO;
          end else begin
            state_next = i2cm_pkg::ST_STO_A;
          end
        end
        i2cm_pkg::ST_RS_A: state_next = i2cm_pkg::ST_RS_B;
        i2cm_pkg::ST_RS_B: state_next = i2cm_pkg::ST_RS_C;
        i2cm_pkg::ST_RS_C: begin
          shift_byte_next = {device_address, 1'b1};
          bit_count_next  = 4'd0;
          byte_index_next = i2cm_pkg::BYTE_LAST;
          state_next      = i2cm_pkg::ST_BIT_LO;
        end
        i2cm_pkg::ST_RD_LO: state_next = i2cm_pkg::ST_RD_HI;
        i2cm_pkg::ST_RD_HI: begin
          shift_byte_next = rd_shift;
          bit_count_next  = bit_inc;
          if (bit_inc >= i2cm_pkg::BITS_PER_BYTE) begin
            read_byte_next = rd_shift;
            state_next     = i2cm_pkg::ST_NAK_LO;
          end else begin
            state_next = i2cm_pkg::ST_RD_LO;
          end
        end
        i2cm_pkg::ST_NAK_LO: state_next = i2cm_pkg::ST_NAK_HI;
        i2cm_pkg::ST_NAK_HI: state_next = i2cm_pkg::ST_STO_A;
        i2cm_pkg::ST_STO_A:  state_next = i2cm_pkg::ST_STO_B;
        i2cm_pkg::ST_STO_B:  state_next = i2cm_pkg::ST_STO_C;
        i2cm_pkg::ST_STO_C: begin
          state_next = i2cm_pkg::ST_IDLE;
          done       = 1'b1;
        end
        default: state_next = i2cm_pkg::ST_IDLE;
      endcase
    end
  end

  // bus drive follows the updated state
  always_comb begin
    res_new.scl_level = 1'b1;
    res_new.sda_level = 1'b1;
    unique case (state_next)
      i2cm_pkg::ST_STA_B, i2cm_pkg::ST_RS_C, i2cm_pkg::ST_STO_B: begin
        res_new.sda_level = 1'b0;
      end
      i2cm_pkg::ST_BIT_LO: begin
        res_new.scl_level = 1'b0;
        res_new.sda_level = shift_byte_next[7];
      end
      i2cm_pkg::ST_BIT_HI: res_new.sda_level = shift_byte_next[7];
      i2cm_pkg::ST_ACK_LO, i2cm_pkg::ST_RS_A, i2cm_pkg::ST_RD_LO,
      i2cm_pkg::ST_NAK_LO: res_new.scl_level = 1'b0;
      i2cm_pkg::ST_STO_A: begin
        res_new.scl_level = 1'b0;
        res_new.sda_level = 1'b0;
      end
      default: ;
    endcase
    res_new.busy_res  = (state_next != i2cm_pkg::ST_IDLE);
    res_new.done_res  = done;
    res_new.rd_data   = read_byte_next;
    res_new.nack_seen = nack_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= i2cm_pkg::ST_IDLE;
      phase_count <= 8'd0;
      bit_count   <= 4'd0;
      shift_byte  <= 8'd0;
      held_type   <= 1'b0;
      held_reg    <= 8'd0;
      held_data   <= 8'd0;
      read_byte   <= 8'd0;
      nack_flag   <= 1'b0;
      byte_index  <= i2cm_pkg::BYTE_DEV;
    end else if (accept) begin
      state       <= state_next;
      phase_count <= phase_count_next;
      bit_count   <= bit_count_next;
      shift_byte  <= shift_byte_next;
      held_type   <= held_type_next;
      held_reg    <= held_reg_next;
      held_data   <= held_data_next;
      read_byte   <= read_byte_next;
      nack_flag   <= nack_flag_next;
      byte_index  <= byte_index_next;
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_ch.ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ch.ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : res_new;
    end
    if (accept && out_valid && !res_ch.ready) begin
      skid_data <= res_new;
    end
  end

endmodule

/* design/i2cm_checker.sv */
// Port-level checker for the I2C register access master, bound to the top.
// Depends on i2cm_pkg and i2c_master_register_access_defines.svh.
`include "i2c_master_register_access_defines.svh"

module i2cm_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           res_valid,
  input logic           res_ready,
  input i2cm_pkg::res_t res_data
);

  `I2CM_ASSERT(a_res_hold, res_valid && !res_ready |=> res_valid && $stable(res_data), "result beat changed while stalled")
  `I2CM_ASSERT(a_ready_low, !req_ready |-> $past(res_valid && !res_ready), "request side stalled without a stalled result")
  `I2CM_ASSERT(a_no_spurious, res_valid |-> $past(req_valid && req_ready) || $past(res_valid && !res_ready) || $past(!req_ready), "result beat without a request beat")
  `I2CM_ASSERT_ALWAYS(a_done_idle, res_valid && res_data.done_res |-> !res_data.busy_res && res_data.scl_level && res_data.sda_level, "stop completion while bus not idle")

endmodule

bind i2c_master_register_access i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_ch.valid),
  .req_ready (req_ch.ready),
  .res_valid (res_ch.valid),
  .res_ready (res_ch.ready),
  .res_data  (res_ch.data)
);
